[rtl/core/spq_pkg.sv]
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;
	localparam int PRIO_BITS_DEF    = 16;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/spq_in_if.sv]
`default_nettype none

interface spq_in_if #(
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [PAYLOAD_BITS-1:0]     payload;
	logic signed [PRIO_BITS-1:0] prio;

	modport source (output valid, op, payload, prio, input ready);
	modport sink   (input valid, op, payload, prio, output ready);
endinterface

`default_nettype wire

[rtl/core/spq_out_if.sv]
`default_nettype none

interface spq_out_if #(
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	parameter int OCC_BITS     = $clog2(spq_pkg::DEPTH_DEF + 1)
);
	logic                    valid;
	logic                    ready;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [1:0]              status;
	logic [OCC_BITS-1:0]     occupancy;

	modport source (output valid, out_payload, status, occupancy, input ready);
	modport sink   (input valid, out_payload, status, occupancy, output ready);
endinterface

`default_nettype wire

[rtl/core/spq_cell.sv]
`default_nettype none

module spq_cell #(
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire spq_pkg::cell_ctrl_t          ctrl,
	input  wire        [PAYLOAD_BITS-1:0]     new_payload,
	input  wire signed [PRIO_BITS-1:0]        new_prio,
	input  wire                               left_keep,
	input  wire                               left_valid,
	input  wire        [PAYLOAD_BITS-1:0]     left_payload,
	input  wire signed [PRIO_BITS-1:0]        left_prio,
	input  wire                               right_valid,
	input  wire        [PAYLOAD_BITS-1:0]     right_payload,
	input  wire signed [PRIO_BITS-1:0]        right_prio,
	output logic                              keep,
	output logic                              valid,
	output logic       [PAYLOAD_BITS-1:0]     payload,
	output logic signed [PRIO_BITS-1:0]       prio
);

	logic                        valid_q;
	logic [PAYLOAD_BITS-1:0]     payload_q;
	logic signed [PRIO_BITS-1:0] prio_q;
	logic                        take_new;

	// An entry of equal or higher priority stays in place on an enqueue.
	assign keep     = valid_q && (prio_q >= new_prio);
	assign take_new = !keep && left_keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.enq && !keep) begin
			valid_q <= take_new ? 1'b1 : left_valid;
		end else if (ctrl.deq) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.enq && !keep) begin
			payload_q <= take_new ? new_payload : left_payload;
			prio_q    <= take_new ? new_prio : left_prio;
		end else if (ctrl.deq) begin
			payload_q <= right_payload;
			prio_q    <= right_prio;
		end
	end

	assign valid   = valid_q;
	assign payload = payload_q;
	assign prio    = prio_q;

endmodule

`default_nettype wire

[rtl/core/sorted_priority_queue.sv]
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    op, payload, prio
// rsp      out  valid/ready    out_payload, status, occupancy
//
// One item is accepted per cycle while req.ready is high; every cell of the chain
// compares its priority with the incoming one in parallel. On an enqueue the cells
// behind the insertion point shift one place toward the tail, on a dequeue all shift
// toward the head. Results go to the output register; req.ready is high whenever that register is empty or being taken.
// Reset clears the cell valid bits, the entry count and the output valid bit.

`default_nettype none

module sorted_priority_queue #(
	parameter int DEPTH        = spq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	parameter int PRIO_BITS    = spq_pkg::PRIO_BITS_DEF
) (
	input wire        clk,
	input wire        arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp
);

	localparam int OCC_BITS = $clog2(DEPTH + 1);

	logic                        cell_keep    [DEPTH];
	logic                        cell_valid   [DEPTH];
	logic [PAYLOAD_BITS-1:0]     cell_payload [DEPTH];
	logic signed [PRIO_BITS-1:0] cell_prio    [DEPTH];
	logic [DEPTH-1:0]            valid_vec;

	logic                    accept;
	logic                    enq_ok;
	logic                    deq_ok;
	spq_pkg::cell_ctrl_t     ctrl;
	logic [OCC_BITS-1:0]     count_q;
	logic [OCC_BITS-1:0]     count_next;
	spq_pkg::status_t        status_next;

	logic                    rsp_valid_q;
	logic [PAYLOAD_BITS-1:0] rsp_payload_q;
	spq_pkg::status_t        rsp_status_q;
	logic [OCC_BITS-1:0]     rsp_occ_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign enq_ok    = accept && (req.op == spq_pkg::OP_ENQ) && (count_q != OCC_BITS'(DEPTH));
	assign deq_ok    = accept && (req.op == spq_pkg::OP_DEQ) && (count_q != '0);
	assign ctrl.enq  = enq_ok;
	assign ctrl.deq  = deq_ok;

	always_comb begin
		count_next  = count_q;
		status_next = spq_pkg::ST_OK;
		if (enq_ok) begin
			count_next = count_q + 1'b1;
		end else if (deq_ok) begin
			count_next = count_q - 1'b1;
		end else if (req.op == spq_pkg::OP_ENQ) begin
			status_next = spq_pkg::ST_FULL;
		end else begin
			status_next = spq_pkg::ST_EMPTY;
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                        lk;
			logic                        lv;
			logic [PAYLOAD_BITS-1:0]     lp;
			logic signed [PRIO_BITS-1:0] lq;
			logic                        rv;
			logic [PAYLOAD_BITS-1:0]     rp;
			logic signed [PRIO_BITS-1:0] rq;

			if (i == 0) begin : g_head
				assign lk = 1'b1;
				assign lv = 1'b0;
				assign lp = '0;
				assign lq = '0;
			end else begin : g_body
				assign lk = cell_keep[i-1];
				assign lv = cell_valid[i-1];
				assign lp = cell_payload[i-1];
				assign lq = cell_prio[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign rv = 1'b0;
				assign rp = '0;
				assign rq = '0;
			end else begin : g_inner
				assign rv = cell_valid[i+1];
				assign rp = cell_payload[i+1];
				assign rq = cell_prio[i+1];
			end

			spq_cell #(
				.PAYLOAD_BITS (PAYLOAD_BITS),
				.PRIO_BITS    (PRIO_BITS)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctrl          (ctrl),
				.new_payload   (req.payload),
				.new_prio      (req.prio),
				.left_keep     (lk),
				.left_valid    (lv),
				.left_payload  (lp),
				.left_prio     (lq),
				.right_valid   (rv),
				.right_payload (rp),
				.right_prio    (rq),
				.keep          (cell_keep[i]),
				.valid         (cell_valid[i]),
				.payload       (cell_payload[i]),
				.prio          (cell_prio[i])
			);

			assign valid_vec[i] = cell_valid[i];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_payload_q <= deq_ok ? cell_payload[0] : '0;
			rsp_status_q  <= status_next;
			rsp_occ_q     <= count_next;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.out_payload = rsp_payload_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.occupancy   = rsp_occ_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OCC_BITS'(DEPTH))
		else $error("entry count exceeds depth");

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_vec[1] |-> (cell_prio[0] >= cell_prio[1]))
		else $error("head cells out of priority order");

	a_deq_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		deq_ok |=> (count_q == $past(count_q) - 1'b1))
		else $error("dequeue did not remove an entry");

endmodule

`default_nettype wire

[sim/sorted_priority_queue_test.sv]
`default_nettype none

module sorted_priority_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = spq_pkg::DEPTH_DEF;
	localparam int PW = spq_pkg::PAYLOAD_BITS_DEF;
	localparam int QW = spq_pkg::PRIO_BITS_DEF;
	localparam int OW = $clog2(spq_pkg::DEPTH_DEF + 1);
	localparam int RANDOM_ITEMS = 800;
	localparam int LONG_HOLD = 150;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [PW-1:0]    out_payload;
		spq_pkg::status_t status;
		logic [OW-1:0]    occupancy;
	} response_t;

	typedef struct packed {
		logic                 op;
		logic [PW-1:0]        payload;
		logic signed [QW-1:0] prio;
		bit                   typed;
		response_t            want;
	} directed_row_t;

	localparam response_t NO_WANT = '{32'h0, spq_pkg::ST_OK, 5'd0};
	localparam int N_ROWS = 22;

	// Dequeue the empty queue, fill it through both priority extremes and several ties,
	// overflow it, then drain a few entries from the top.
	localparam directed_row_t DIRECTED[N_ROWS] = '{
		'{spq_pkg::OP_DEQ, 32'h0000_0000, 16'sh0000, 1'b1, '{32'h0, spq_pkg::ST_EMPTY, 5'd0}},
		'{spq_pkg::OP_ENQ, 32'hFFFF_FFFF, 16'sh7FFF, 1'b1, '{32'h0, spq_pkg::ST_OK, 5'd1}},
		'{spq_pkg::OP_ENQ, 32'h0000_0000, 16'sh8000, 1'b1, '{32'h0, spq_pkg::ST_OK, 5'd2}},
		'{spq_pkg::OP_ENQ, 32'h0000_0001, 16'sh0000, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0002, 16'sh0000, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0003, 16'shFFFF, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0004, 16'sh0001, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h8000_0000, 16'sh7FFF, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h7FFF_FFFF, 16'sh8000, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'hA5A5_A5A5, 16'sh5A5A, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h5A5A_5A5A, 16'shA5A5, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0005, 16'sh0000, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0006, 16'shFFFE, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0007, 16'sh0002, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0008, 16'sh0064, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_0009, 16'shFF9C, 1'b0, NO_WANT},
		'{spq_pkg::OP_ENQ, 32'h0000_000A, 16'sh0000, 1'b1, '{32'h0, spq_pkg::ST_OK, 5'd16}},
		'{spq_pkg::OP_ENQ, 32'hDEAD_BEEF, 16'sh0001, 1'b1, '{32'h0, spq_pkg::ST_FULL, 5'd16}},
		'{spq_pkg::OP_DEQ, 32'h0000_0000, 16'sh0000, 1'b1,
			'{32'hFFFF_FFFF, spq_pkg::ST_OK, 5'd15}},
		'{spq_pkg::OP_DEQ, 32'h1234_5678, 16'sh1234, 1'b0, NO_WANT},
		'{spq_pkg::OP_DEQ, 32'hFFFF_FFFF, 16'shFFFF, 1'b0, NO_WANT},
		'{spq_pkg::OP_DEQ, 32'h0000_0000, 16'sh8000, 1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n;

	spq_in_if  req_if();
	spq_out_if rsp_if();

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #6ns clk = ~clk;

	logic [PW-1:0]        held_payload[DEPTH];
	logic signed [QW-1:0] held_prio[DEPTH];
	int                   held_count;
	response_t            expected_responses[$];
	int                   errors;
	int                   hold_req;
	int                   burst_left;

	task automatic predict_response(input logic op, input logic [PW-1:0] payload,
			input logic signed [QW-1:0] prio, output response_t res);
		int pos;
		res = '{'0, spq_pkg::ST_OK, '0};
		if (op == spq_pkg::OP_ENQ) begin
			if (held_count >= DEPTH) begin
				res.status = spq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] >= prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_payload[i] = held_payload[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_payload[pos] = payload;
				held_prio[pos] = prio;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				res.status = spq_pkg::ST_EMPTY;
			end else begin
				res.out_payload = held_payload[0];
				for (int i = 1; i < held_count; i++) begin
					held_payload[i-1] = held_payload[i];
					held_prio[i-1] = held_prio[i];
				end
				held_count--;
			end
		end
		res.occupancy = OW'(held_count);
	endtask

	task automatic offer_request(input logic op, input logic [PW-1:0] payload,
			input logic signed [QW-1:0] prio, input bit typed, input response_t want);
		int gap;
		response_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.payload <= payload;
		req_if.prio <= prio;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		predict_response(op, payload, prio, predicted);
		expected_responses.push_back(typed ? want : predicted);
	endtask

	task automatic pause_until_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_responses.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [QW-1:0] pick_prio();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3, 4, 5: return QW'($urandom_range(0, 6) - 3);
			default: return QW'($urandom);
		endcase
	endfunction

	function automatic logic [PW-1:0] pick_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PW'($urandom);
		endcase
	endfunction

	initial begin
		int seg_left;
		int enq_pct;
		logic op;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = spq_pkg::OP_ENQ;
		req_if.payload = '0;
		req_if.prio = '0;
		errors = 0;
		hold_req = 0;
		burst_left = 0;
		held_count = 0;
		seg_left = 0;
		enq_pct = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			offer_request(DIRECTED[r].op, DIRECTED[r].payload, DIRECTED[r].prio,
				DIRECTED[r].typed, DIRECTED[r].want);
		pause_until_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: enq_pct = 85;
					1: enq_pct = 50;
					default: enq_pct = 15;
				endcase
			end
			seg_left--;
			if (n == 300) begin
				hold_req <= hold_req + 1;
				burst_left = 200;
			end
			if (n == 550)
				pause_until_drained();
			op = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
			offer_request(op, pick_payload(), pick_prio(), 1'b0, NO_WANT);
		end

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int hold_seen;
		int mode;
		int mode_left;
		hold_seen = 0;
		mode = 0;
		mode_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(50, 200);
				end
				mode_left--;
				case (mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= 1'($urandom_range(0, 1));
					default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		response_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_responses.size() == 0) begin
				$error("unexpected result: out_payload %h status %0d occupancy %0d",
					rsp_if.out_payload, rsp_if.status, rsp_if.occupancy);
				errors++;
			end else begin
				want = expected_responses.pop_front();
				if (rsp_if.out_payload !== want.out_payload) begin
					$error("out_payload: expected %h, got %h", want.out_payload,
						rsp_if.out_payload);
					errors++;
				end
				if (rsp_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_if.status);
					errors++;
				end
				if (rsp_if.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						rsp_if.occupancy);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int quiet_cycles;
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule

`default_nettype wire

[sorted_priority_queue.f]
rtl/core/spq_pkg.sv
rtl/core/spq_in_if.sv
rtl/core/spq_out_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
sim/sorted_priority_queue_test.sv
